@@ rtl/lgs_pkg.sv @@
// shared types, constants and sizes for the life grid generation step unit
`default_nettype none

package lgs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int DIM_W   = 7;
    localparam int COORD_W = 10;
    localparam int KIND_W  = 2;
    localparam int EXT_W   = 11;
    localparam int NB_W    = 4;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int COL_LO   = 0;
    localparam int ROW_LO   = COORD_W;
    localparam int RANGE_BIT = 0;
    localparam int VALUE_BIT = 1;
    localparam int EMPTY_BIT = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [NB_W-1:0] NB_BIRTH = 4'd3;
    localparam logic [NB_W-1:0] NB_KEEP  = 4'd2;

    localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_STEP_FIRST,
        ST_STEP_ROW,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] prev;
        logic [MAX_WIDTH-1:0] cur;
        logic [MAX_WIDTH-1:0] nxt;
    } t_row_win;

endpackage

`default_nettype wire

@@ rtl/lgs_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/lgs_row_engine.sv @@
// next-generation logic for one grid row from the rows above, at and below
`default_nettype none

module lgs_row_engine (
    input  wire logic                    [lgs_pkg::EXT_W-1:0]     i_active_w,
    input  wire lgs_pkg::t_row_win                                i_win,
    output logic                         [lgs_pkg::MAX_WIDTH-1:0] o_row,
    output logic                                                  o_any
);

    logic [lgs_pkg::MAX_WIDTH+1:0] pad_prev;
    logic [lgs_pkg::MAX_WIDTH+1:0] pad_cur;
    logic [lgs_pkg::MAX_WIDTH+1:0] pad_nxt;
    logic [lgs_pkg::NB_W-1:0]      nb_cnt [lgs_pkg::MAX_WIDTH];
    logic [lgs_pkg::MAX_WIDTH-1:0] col_mask;

    always_comb begin
        pad_prev = {1'b0, i_win.prev, 1'b0};
        pad_cur  = {1'b0, i_win.cur, 1'b0};
        pad_nxt  = {1'b0, i_win.nxt, 1'b0};
        for (int x = 0; x < lgs_pkg::MAX_WIDTH; x++) begin
            nb_cnt[x] = lgs_pkg::NB_W'(pad_prev[x]) + lgs_pkg::NB_W'(pad_prev[x+1])
                      + lgs_pkg::NB_W'(pad_prev[x+2]) + lgs_pkg::NB_W'(pad_cur[x])
                      + lgs_pkg::NB_W'(pad_cur[x+2]) + lgs_pkg::NB_W'(pad_nxt[x])
                      + lgs_pkg::NB_W'(pad_nxt[x+1]) + lgs_pkg::NB_W'(pad_nxt[x+2]);
            col_mask[x] = (lgs_pkg::EXT_W'(x) < i_active_w);
            o_row[x] = col_mask[x] && ((nb_cnt[x] == lgs_pkg::NB_BIRTH)
                       || (pad_cur[x+1] && (nb_cnt[x] == lgs_pkg::NB_KEEP)));
        end
        o_any = |o_row;
    end

endmodule

`default_nettype wire

@@ rtl/life_grid_generation_step_unit.sv @@
// top level: life grid held one row per ram word, rule b3/s23 step, apb config
// a set, read or unused kind passes through an access state and then a response state;
//   a step reads the first row, then computes and writes one row per cycle up to active_height
//   (straight to the response state at zero height); only one item is in flight at a time,
//   and a new one is accepted only after the previous result enters the output register
// reset (synchronous, active low) and every dimension write start a clearing pass over all
//   MAX_HEIGHT rows (64 by default) during which no item is accepted
`default_nettype none

module life_grid_generation_step_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // col [9:0], row [19:10], zero [23:20]
    input  wire logic [lgs_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // kind [1:0]
    input  wire logic [lgs_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // in_range [0], cell_value [1], grid_empty [2], zero [7:3]
    output logic      [lgs_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lgs_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [lgs_pkg::PDATA_W-1:0]     pwdata,
    output logic      [lgs_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready
);

    lgs_pkg::t_state r_state;
    lgs_pkg::t_state n_state;

    logic [lgs_pkg::DIM_W-1:0]     r_width;
    logic [lgs_pkg::DIM_W-1:0]     r_height;
    logic [lgs_pkg::EXT_W-1:0]     active_w;
    logic [lgs_pkg::EXT_W-1:0]     active_h;
    logic [lgs_pkg::EXT_W-1:0]     r_row;
    logic [lgs_pkg::ROW_W-1:0]     r_acc_row;
    logic [lgs_pkg::COL_W-1:0]     r_acc_col;
    logic [lgs_pkg::KIND_W-1:0]    r_kind;
    logic                          r_inside;
    logic                          r_any;
    logic                          r_res_range;
    logic                          r_res_val;
    logic [lgs_pkg::MAX_WIDTH-1:0] r_prev;
    logic [lgs_pkg::MAX_WIDTH-1:0] r_cur;
    logic                          r_m_tvalid;
    logic                          r_m_range;
    logic                          r_m_val;
    logic                          r_m_empty;

    logic                          cfg_wr;
    logic                          cfg_idx;
    logic                          s_acc;
    logic                          out_free;
    logic                          next_ok;
    logic [lgs_pkg::KIND_W-1:0]    in_kind;
    logic [lgs_pkg::COORD_W-1:0]   in_col;
    logic [lgs_pkg::COORD_W-1:0]   in_row;
    logic                          in_inside;
    logic                          acc_set;

    logic                          ram_we;
    logic [lgs_pkg::ROW_W-1:0]     ram_waddr;
    logic [lgs_pkg::MAX_WIDTH-1:0] ram_wdata;
    logic [lgs_pkg::ROW_W-1:0]     ram_raddr;
    logic [lgs_pkg::MAX_WIDTH-1:0] ram_rdata;

    lgs_pkg::t_row_win             win;
    logic [lgs_pkg::MAX_WIDTH-1:0] new_row;
    logic                          new_any;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[2];

    always_comb begin
        case (cfg_idx)
            lgs_pkg::REG_WIDTH:  prdata = lgs_pkg::PDATA_W'(r_width);
            lgs_pkg::REG_HEIGHT: prdata = lgs_pkg::PDATA_W'(r_height);
            default:             prdata = '0;
        endcase
    end

    // active dimensions
    assign active_w = (lgs_pkg::EXT_W'(r_width) > lgs_pkg::EXT_W'(lgs_pkg::MAX_WIDTH))
                    ? lgs_pkg::EXT_W'(lgs_pkg::MAX_WIDTH) : lgs_pkg::EXT_W'(r_width);
    assign active_h = (lgs_pkg::EXT_W'(r_height) > lgs_pkg::EXT_W'(lgs_pkg::MAX_HEIGHT))
                    ? lgs_pkg::EXT_W'(lgs_pkg::MAX_HEIGHT) : lgs_pkg::EXT_W'(r_height);

    // input decode
    assign in_kind   = i_s_tuser[lgs_pkg::KIND_W-1:0];
    assign in_col    = i_s_tdata[lgs_pkg::COL_LO +: lgs_pkg::COORD_W];
    assign in_row    = i_s_tdata[lgs_pkg::ROW_LO +: lgs_pkg::COORD_W];
    assign in_inside = !in_col[lgs_pkg::COORD_W-1] && !in_row[lgs_pkg::COORD_W-1]
                     && (lgs_pkg::EXT_W'(in_col) < active_w)
                     && (lgs_pkg::EXT_W'(in_row) < active_h);

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign next_ok  = (r_row + lgs_pkg::EXT_W'(1)) < active_h;
    assign acc_set  = (r_kind == lgs_pkg::KIND_SET) && r_inside;

    // row window
    assign win.prev = r_prev;
    assign win.cur  = r_cur;
    assign win.nxt  = next_ok ? ram_rdata : '0;

    lgs_row_engine u_row_engine (
        .i_active_w (active_w),
        .i_win      (win),
        .o_row      (new_row),
        .o_any      (new_any)
    );

    lgs_ram #(
        .WIDTH (lgs_pkg::MAX_WIDTH),
        .DEPTH (lgs_pkg::MAX_HEIGHT)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgs_pkg::ST_CLEAR: begin
                if (r_row == lgs_pkg::EXT_W'(lgs_pkg::MAX_HEIGHT - 1)) begin
                    n_state = lgs_pkg::ST_IDLE;
                end
            end
            lgs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (in_kind == lgs_pkg::KIND_STEP) begin
                        n_state = (active_h == '0) ? lgs_pkg::ST_RESP
                                                   : lgs_pkg::ST_STEP_FIRST;
                    end else begin
                        n_state = lgs_pkg::ST_ACCESS;
                    end
                end
            end
            lgs_pkg::ST_ACCESS:     n_state = lgs_pkg::ST_RESP;
            lgs_pkg::ST_STEP_FIRST: n_state = lgs_pkg::ST_STEP_ROW;
            lgs_pkg::ST_STEP_ROW: begin
                if (!next_ok) begin
                    n_state = lgs_pkg::ST_RESP;
                end
            end
            lgs_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = lgs_pkg::ST_IDLE;
                end
            end
            default: n_state = lgs_pkg::ST_IDLE;
        endcase
        if (cfg_wr) begin
            n_state = lgs_pkg::ST_CLEAR;
        end
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_row[lgs_pkg::ROW_W-1:0];
        ram_wdata  = '0;
        ram_raddr  = r_row[lgs_pkg::ROW_W-1:0];
        case (r_state)
            lgs_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            lgs_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                ram_raddr  = (in_kind == lgs_pkg::KIND_STEP) ? '0
                                                             : in_row[lgs_pkg::ROW_W-1:0];
            end
            lgs_pkg::ST_ACCESS: begin
                ram_we    = acc_set;
                ram_waddr = r_acc_row;
                ram_wdata = ram_rdata
                          | (lgs_pkg::MAX_WIDTH'(1) << r_acc_col);
            end
            lgs_pkg::ST_STEP_FIRST: begin
                ram_raddr = r_row[lgs_pkg::ROW_W-1:0] + lgs_pkg::ROW_W'(1);
            end
            lgs_pkg::ST_STEP_ROW: begin
                ram_we    = 1'b1;
                ram_wdata = new_row;
                ram_raddr = r_row[lgs_pkg::ROW_W-1:0] + lgs_pkg::ROW_W'(2);
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lgs_pkg::ST_CLEAR;
            r_row      <= '0;
            r_any      <= 1'b0;
            r_m_tvalid <= 1'b0;
            r_width    <= lgs_pkg::DIM_RESET;
            r_height   <= lgs_pkg::DIM_RESET;
        end else begin
            r_state <= n_state;
            if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                lgs_pkg::ST_CLEAR: begin
                    r_row <= r_row + lgs_pkg::EXT_W'(1);
                end
                lgs_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        r_row <= '0;
                        if (in_kind == lgs_pkg::KIND_STEP) begin
                            r_any <= 1'b0;
                        end
                    end
                end
                lgs_pkg::ST_ACCESS: begin
                    if (acc_set) begin
                        r_any <= 1'b1;
                    end
                end
                lgs_pkg::ST_STEP_ROW: begin
                    r_row <= r_row + lgs_pkg::EXT_W'(1);
                    r_any <= r_any | new_any;
                end
                lgs_pkg::ST_RESP: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                    end
                end
                default: begin
                    r_any <= r_any;
                end
            endcase
            if (cfg_wr) begin
                if (cfg_idx == lgs_pkg::REG_WIDTH) begin
                    r_width <= pwdata[lgs_pkg::DIM_W-1:0];
                end else begin
                    r_height <= pwdata[lgs_pkg::DIM_W-1:0];
                end
                r_row <= '0;
                r_any <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            lgs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    r_kind      <= in_kind;
                    r_inside    <= in_inside;
                    r_acc_row   <= in_row[lgs_pkg::ROW_W-1:0];
                    r_acc_col   <= in_col[lgs_pkg::COL_W-1:0];
                    r_res_range <= 1'b1;
                    r_res_val   <= 1'b0;
                end
            end
            lgs_pkg::ST_ACCESS: begin
                r_res_range <= r_inside && ((r_kind == lgs_pkg::KIND_SET)
                                            || (r_kind == lgs_pkg::KIND_READ));
                r_res_val   <= r_inside && (r_kind == lgs_pkg::KIND_READ)
                               && ram_rdata[r_acc_col];
            end
            lgs_pkg::ST_STEP_FIRST: begin
                r_prev <= '0;
                r_cur  <= ram_rdata;
            end
            lgs_pkg::ST_STEP_ROW: begin
                r_prev <= r_cur;
                r_cur  <= win.nxt;
            end
            lgs_pkg::ST_RESP: begin
                if (out_free) begin
                    r_m_range <= r_res_range;
                    r_m_val   <= r_res_val;
                    r_m_empty <= !r_any;
                end
            end
            default: begin
                r_kind <= r_kind;
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;

    always_comb begin
        o_m_tdata                     = '0;
        o_m_tdata[lgs_pkg::RANGE_BIT] = r_m_range;
        o_m_tdata[lgs_pkg::VALUE_BIT] = r_m_val;
        o_m_tdata[lgs_pkg::EMPTY_BIT] = r_m_empty;
    end

    // checks
    a_cfg_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == lgs_pkg::ST_CLEAR) && !o_s_tready)
        else $error("dimension write did not start a clearing pass");

    a_step_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgs_pkg::ST_STEP_ROW) |-> (r_row < active_h))
        else $error("step row beyond active height");

    a_clear_grid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgs_pkg::ST_CLEAR) |-> !r_any)
        else $error("live flag set while clearing");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == lgs_pkg::ST_RESP))
        else $error("result loaded outside response state");

endmodule

`default_nettype wire

@@ tb/life_grid_checker.sv @@
// checker for the life grid unit: predicts every result and compares it with the block's answer
`default_nettype none

module life_grid_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    // col [9:0], row [19:10], zero [23:20]
    input  wire logic [lgs_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // kind [1:0]
    input  wire logic [lgs_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // in_range [0], cell_value [1], grid_empty [2], zero [7:3]
    input  wire logic [lgs_pkg::M_TDATA_W-1:0]   i_m_tdata,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic                            i_pready,
    input  wire logic [lgs_pkg::PADDR_W-1:0]     i_paddr,
    input  wire logic [lgs_pkg::PDATA_W-1:0]     i_pwdata,
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_checked
);

    import lgs_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic in_range;
        logic cell_value;
        logic grid_empty;
    } t_reply;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             alive [0:CELLS-1];
    int               live_cells;
    int               errors  = 0;
    int               checked = 0;
    t_reply           replies_due [$];

    function automatic int clip(int dim, int lim);
        return (dim > lim) ? lim : dim;
    endfunction

    function automatic void clear_grid();
        foreach (alive[i]) alive[i] = 1'b0;
        live_cells = 0;
    endfunction

    function automatic void next_generation();
        int   w;
        int   h;
        int   n;
        int   cnt;
        int   idx;
        logic old [0:CELLS-1];
        w   = clip(width_reg, MAX_WIDTH);
        h   = clip(height_reg, MAX_HEIGHT);
        cnt = 0;
        old = alive;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if ((dy != 0 || dx != 0) && y + dy >= 0 && y + dy < h &&
                            x + dx >= 0 && x + dx < w) begin
                            n += old[(y + dy) * MAX_WIDTH + x + dx];
                        end
                    end
                end
                idx        = y * MAX_WIDTH + x;
                alive[idx] = (n == 3) || (old[idx] && n == 2);
                cnt       += alive[idx];
            end
        end
        live_cells = cnt;
    endfunction

    function automatic t_reply predict_reply(logic [KIND_W-1:0] kind, int c, int r);
        t_reply rep;
        logic   in_grid;
        int     idx;
        in_grid = c >= 0 && r >= 0 && c < clip(width_reg, MAX_WIDTH) &&
                  r < clip(height_reg, MAX_HEIGHT);
        idx     = r * MAX_WIDTH + c;
        rep     = '0;
        case (kind)
            KIND_SET: begin
                if (in_grid) begin
                    if (!alive[idx]) begin
                        alive[idx] = 1'b1;
                        live_cells++;
                    end
                    rep.in_range = 1'b1;
                end
            end
            KIND_STEP: begin
                next_generation();
                rep.in_range = 1'b1;
            end
            KIND_READ: begin
                if (in_grid) begin
                    rep.in_range   = 1'b1;
                    rep.cell_value = alive[idx];
                end
            end
            default: ;
        endcase
        rep.grid_empty = (live_cells == 0);
        return rep;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            clear_grid();
            replies_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %03b",
                             $time, i_m_tdata[EMPTY_BIT:RANGE_BIT]);
                end else begin
                    want = replies_due.pop_front();
                    check_field("in_range", want.in_range, i_m_tdata[RANGE_BIT]);
                    check_field("cell_value", want.cell_value, i_m_tdata[VALUE_BIT]);
                    check_field("grid_empty", want.grid_empty, i_m_tdata[EMPTY_BIT]);
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(predict_reply(i_s_tuser,
                                                    $signed(i_s_tdata[COL_LO +: COORD_W]),
                                                    $signed(i_s_tdata[ROW_LO +: COORD_W])));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_WIDTH) begin
                    width_reg = i_pwdata[DIM_W-1:0];
                end else begin
                    height_reg = i_pwdata[DIM_W-1:0];
                end
                clear_grid();
            end
        end
        o_outstanding <= replies_due.size();
        o_mismatches  <= errors;
        o_checked     <= checked;
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench top for the life grid unit: clock, reset, stimulus, handshake idling and verdict
`default_nettype none

module tb;

    import lgs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int STALL_MAX    = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = MAX_HEIGHT + 8;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 12;
    localparam int WINDOW       = 8;

    localparam int PHASE_W [NUM_PHASES] = '{3, 1, 0, 7, 127, 64, 1, 8, 0, 64};
    localparam int PHASE_H [NUM_PHASES] = '{3, 1, 5, 0, 127, 1, 64, 6, 0, 64};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data    = '0;
    logic [S_TUSER_W-1:0]  s_kind    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PADDR_W-1:0]    paddr     = '0;
    logic [PDATA_W-1:0]    pwdata    = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int   mismatches;
    int   outstanding;
    int   checked;
    int   sent        = 0;
    int   steps       = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    logic quiet       = 1'b0;

    initial begin
        forever #1 clk = ~clk;
    end

    life_grid_generation_step_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_kind),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    life_grid_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tuser     (s_kind),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // result side back-pressure, a fresh stall drawn per transaction
    always @(posedge clk) begin
        int draw;
        if (!rst_n) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            draw        = quiet ? 0 : $urandom_range(0, STALL_MAX);
            stall_left <= draw;
            m_ready    <= (draw == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row);
        int                   gap;
        logic [S_TDATA_W-1:0] d;
        gap                    = quiet ? 0 : $urandom_range(0, STALL_MAX);
        d                      = '0;
        d[COL_LO +: COORD_W]   = col;
        d[ROW_LO +: COORD_W]   = row;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        s_kind  <= kind;
        do @(posedge clk); while (!s_ready);
        sent++;
        if (kind == KIND_STEP) steps++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic wait_ready();
        do @(posedge clk); while (!s_ready);
    endtask

    task automatic write_reg(input logic idx, input int dim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() << DIM_W) | dim[DIM_W-1:0];
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_item(input int aw, input int ah, input int bc, input int br);
        int                  pick;
        logic [KIND_W-1:0]   kind;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        col  = COORD_W'($urandom());
        row  = COORD_W'($urandom());
        if (aw > 0 && ah > 0) begin
            col = COORD_W'(bc + $urandom_range(0, ((aw < WINDOW) ? aw : WINDOW) - 1));
            row = COORD_W'(br + $urandom_range(0, ((ah < WINDOW) ? ah : WINDOW) - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            kind = KIND_SET;
        end else if (pick < 70) begin
            kind = KIND_READ;
        end else if (pick < 85) begin
            kind = KIND_STEP;
        end else if (pick < 95) begin
            kind = $urandom_range(0, 1) ? KIND_SET : KIND_READ;
            case ($urandom_range(0, 3))
                0: begin
                    col = COORD_W'($urandom());
                    row = COORD_W'($urandom());
                end
                1: col = COORD_W'(aw);
                2: row = COORD_W'(ah);
                default: col = '1;
            endcase
        end else begin
            kind = KIND_UNUSED;
        end
        send_item(kind, col, row);
    endtask

    initial begin
        int aw;
        int ah;
        int w;
        int h;
        int bc;
        int br;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_ready();

        // default 64 by 64 grid
        send_item(KIND_READ, 10'd0, 10'd0);
        send_item(KIND_STEP, 10'd0, 10'd0);
        send_item(KIND_SET, 10'd0, 10'd0);
        send_item(KIND_SET, 10'd63, 10'd63);
        send_item(KIND_SET, 10'd0, 10'd0);
        send_item(KIND_READ, 10'd0, 10'd0);
        send_item(KIND_READ, 10'd63, 10'd63);
        send_item(KIND_SET, 10'h3FF, 10'd0);
        send_item(KIND_SET, 10'd64, 10'd0);
        send_item(KIND_READ, 10'd0, 10'd64);
        send_item(KIND_READ, 10'h200, 10'h200);
        send_item(KIND_SET, 10'h1FF, 10'h1FF);
        send_item(KIND_READ, 10'h3FF, 10'h3FF);
        send_item(KIND_UNUSED, 10'd1, 10'd1);
        send_item(KIND_STEP, 10'd0, 10'd0);
        // blinker oscillates between rows and columns
        send_item(KIND_SET, 10'd10, 10'd5);
        send_item(KIND_SET, 10'd11, 10'd5);
        send_item(KIND_SET, 10'd12, 10'd5);
        send_item(KIND_STEP, 10'd0, 10'd0);
        send_item(KIND_READ, 10'd11, 10'd4);
        send_item(KIND_READ, 10'd11, 10'd6);
        send_item(KIND_READ, 10'd10, 10'd5);
        send_item(KIND_STEP, 10'd0, 10'd0);
        send_item(KIND_READ, 10'd10, 10'd5);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            w = PHASE_W[p];
            h = PHASE_H[p];
            if (p == NUM_PHASES - 2) begin
                w = $urandom_range(0, 127);
                h = $urandom_range(0, 127);
            end
            write_reg(REG_WIDTH, w);
            wait_ready();
            write_reg(REG_HEIGHT, h);
            wait_ready();
            aw    = (w > MAX_WIDTH) ? MAX_WIDTH : w;
            ah    = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
            bc    = (aw > WINDOW) ? $urandom_range(0, aw - WINDOW) : 0;
            br    = (ah > WINDOW) ? $urandom_range(0, ah - WINDOW) : 0;
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item(aw, ah, bc, br);
                if (i == PHASE_ITEMS / 2) drain();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d items with %0d generation steps over %0d grid sizes",
                 sent, steps, NUM_PHASES + 1);
        $display("%0d results checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
